@@ src/cvsm_pkg.sv @@
// Shared widths, register codes and types for the concatenated volume mapper.
// No dependencies; used by every module of the block.
`default_nettype none

package cvsm_pkg;

  localparam int SectorW    = 48;  // logical sector, count, size, base, length
  localparam int PhysW      = 49;  // base plus in-volume offset
  localparam int SumW       = 50;  // running sum of up to four volume sizes
  localparam int VolIdxW    = 2;
  localparam int MaxVolumes = 4;

  // config port: 64-bit registers at 8-byte spacing, eight registers
  localparam int CfgDataW  = 64;
  localparam int CfgAddrW  = 6;
  localparam int RegIdxLsb = 3;
  localparam int RegIdxW   = 3;

  // top bit of the register index picks the group
  localparam logic RegGroupSize = 1'b0;
  localparam logic RegGroupBase = 1'b1;

  localparam int DefNumVolumes = 4;

  typedef struct packed {
    logic rd;
    logic past_end;
  } ctl_t;

endpackage

`default_nettype wire

@@ src/cvsm_regs.sv @@
// Configuration registers: per-volume size and base, APB-style access.
// Depends on cvsm_pkg.
`default_nettype none

module cvsm_regs #(
  parameter int NUM_VOLUMES = cvsm_pkg::DefNumVolumes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cvsm_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [cvsm_pkg::CfgDataW-1:0] pwdata,
  output logic      [cvsm_pkg::CfgDataW-1:0] prdata,
  output logic      [cvsm_pkg::SectorW-1:0]  vol_size_o [NUM_VOLUMES],
  output logic      [cvsm_pkg::SectorW-1:0]  vol_base_o [NUM_VOLUMES]
);

  logic [cvsm_pkg::SectorW-1:0] size_q [NUM_VOLUMES];
  logic [cvsm_pkg::SectorW-1:0] base_q [NUM_VOLUMES];
  logic [cvsm_pkg::RegIdxW-1:0] reg_idx;
  logic                         reg_grp;
  logic [cvsm_pkg::RegIdxW-2:0] reg_vol;
  logic                         wr_en;

  assign reg_idx = paddr[cvsm_pkg::RegIdxLsb +: cvsm_pkg::RegIdxW];
  assign reg_grp = reg_idx[cvsm_pkg::RegIdxW-1];
  assign reg_vol = reg_idx[cvsm_pkg::RegIdxW-2:0];
  assign wr_en   = psel && penable && pwrite;

  for (genvar i = 0; i < NUM_VOLUMES; i++) begin : g_vol
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        size_q[i] <= '0;
        base_q[i] <= '0;
      end else if (wr_en && (reg_vol == (cvsm_pkg::RegIdxW-1)'(i))) begin
        if (reg_grp == cvsm_pkg::RegGroupBase) begin
          base_q[i] <= pwdata[cvsm_pkg::SectorW-1:0];
        end else begin
          size_q[i] <= pwdata[cvsm_pkg::SectorW-1:0];
        end
      end
    end
    assign vol_size_o[i] = size_q[i];
    assign vol_base_o[i] = base_q[i];
  end

  // volumes beyond NUM_VOLUMES read as zero
  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_VOLUMES; i++) begin
      if (reg_vol == (cvsm_pkg::RegIdxW-1)'(i)) begin
        if (reg_grp == cvsm_pkg::RegGroupSize) begin
          prdata = cvsm_pkg::CfgDataW'(size_q[i]);
        end else begin
          prdata = cvsm_pkg::CfgDataW'(base_q[i]);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/cvsm_split.sv @@
// Request splitter pipeline: volume boundaries, per-volume overlap, length, offset.
// Depends on cvsm_pkg; volume sizes come from cvsm_regs.
`default_nettype none

module cvsm_split #(
  parameter int NUM_VOLUMES = cvsm_pkg::DefNumVolumes
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [cvsm_pkg::SectorW-1:0] start_sector_i,
  input  wire logic [cvsm_pkg::SectorW-1:0] sector_count_i,
  input  wire logic                         is_read_i,
  input  wire logic [cvsm_pkg::SectorW-1:0] vol_size_i [NUM_VOLUMES],
  output logic                              seg_valid_o,
  input  wire logic                         seg_ready_i,
  output cvsm_pkg::ctl_t                    seg_ctl_o,
  output logic      [NUM_VOLUMES-1:0]       seg_mask_o,
  output logic      [cvsm_pkg::SectorW-1:0] seg_off_o [NUM_VOLUMES],
  output logic      [cvsm_pkg::SectorW-1:0] seg_len_o [NUM_VOLUMES]
);

  localparam int NumStages = 5;

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;  // rdy[k]: stage k may load; rdy[NumStages] from downstream

  // stage 1: input register
  logic [cvsm_pkg::SectorW-1:0] s1_start_q, s1_count_q;
  logic                         s1_rd_q;
  // stage 2: request end, pairwise size sums
  logic [cvsm_pkg::SectorW-1:0] s2_start_q;
  logic [cvsm_pkg::PhysW-1:0]   s2_end_q;
  logic [cvsm_pkg::SumW-1:0]    s2_p1_q [NUM_VOLUMES];
  logic                         s2_rd_q;
  logic [cvsm_pkg::SumW-1:0]    p1_d [NUM_VOLUMES];
  // stage 3: volume end boundaries
  logic [cvsm_pkg::SectorW-1:0] s3_start_q;
  logic [cvsm_pkg::PhysW-1:0]   s3_end_q;
  logic [cvsm_pkg::SumW-1:0]    s3_e_q [NUM_VOLUMES];
  logic                         s3_rd_q;
  logic [cvsm_pkg::SumW-1:0]    e_d [NUM_VOLUMES];
  // stage 4: clipped overlap per volume
  logic [cvsm_pkg::SumW-1:0]    s4_lo_q [NUM_VOLUMES];
  logic [cvsm_pkg::SumW-1:0]    s4_hi_q [NUM_VOLUMES];
  logic [cvsm_pkg::SumW-1:0]    s4_eprev_q [NUM_VOLUMES];
  logic                         s4_pe_q, s4_rd_q;
  logic [cvsm_pkg::SumW-1:0]    lo_d [NUM_VOLUMES];
  logic [cvsm_pkg::SumW-1:0]    hi_d [NUM_VOLUMES];
  logic [cvsm_pkg::SumW-1:0]    eprev_d [NUM_VOLUMES];
  // stage 5: segment list
  logic [NUM_VOLUMES-1:0]       s5_mask_q;
  logic [cvsm_pkg::SectorW-1:0] s5_off_q [NUM_VOLUMES];
  logic [cvsm_pkg::SectorW-1:0] s5_len_q [NUM_VOLUMES];
  logic                         s5_pe_q, s5_rd_q;
  logic [cvsm_pkg::SumW-1:0]    len_d [NUM_VOLUMES];
  logic [cvsm_pkg::SumW-1:0]    off_d [NUM_VOLUMES];

  assign rdy[NumStages] = seg_ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  for (genvar i = 0; i < NUM_VOLUMES; i++) begin : g_vol
    if (i % 2 == 1) begin : g_pair
      assign p1_d[i] = cvsm_pkg::SumW'(vol_size_i[i-1]) + cvsm_pkg::SumW'(vol_size_i[i]);
    end else begin : g_single
      assign p1_d[i] = cvsm_pkg::SumW'(vol_size_i[i]);
    end

    if (i >= 2) begin : g_upper
      assign e_d[i] = s2_p1_q[i] + s2_p1_q[1];
    end else begin : g_lower
      assign e_d[i] = s2_p1_q[i];
    end

    if (i == 0) begin : g_first
      assign eprev_d[i] = '0;
    end else begin : g_next
      assign eprev_d[i] = s3_e_q[i-1];
    end

    assign lo_d[i] = (cvsm_pkg::SumW'(s3_start_q) > eprev_d[i]) ?
                     cvsm_pkg::SumW'(s3_start_q) : eprev_d[i];
    assign hi_d[i] = (cvsm_pkg::SumW'(s3_end_q) < s3_e_q[i]) ?
                     cvsm_pkg::SumW'(s3_end_q) : s3_e_q[i];

    // within a touched volume the offset stays below its size and the length does not exceed it
    assign len_d[i] = s4_hi_q[i] - s4_lo_q[i];
    assign off_d[i] = s4_lo_q[i] - s4_eprev_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_start_q <= start_sector_i;
      s1_count_q <= sector_count_i;
      s1_rd_q    <= is_read_i;
    end
    if (rdy[1]) begin
      s2_start_q <= s1_start_q;
      s2_end_q   <= cvsm_pkg::PhysW'(s1_start_q) + cvsm_pkg::PhysW'(s1_count_q);
      s2_p1_q    <= p1_d;
      s2_rd_q    <= s1_rd_q;
    end
    if (rdy[2]) begin
      s3_start_q <= s2_start_q;
      s3_end_q   <= s2_end_q;
      s3_e_q     <= e_d;
      s3_rd_q    <= s2_rd_q;
    end
    if (rdy[3]) begin
      s4_lo_q    <= lo_d;
      s4_hi_q    <= hi_d;
      s4_eprev_q <= eprev_d;
      s4_pe_q    <= cvsm_pkg::SumW'(s3_end_q) > s3_e_q[NUM_VOLUMES-1];
      s4_rd_q    <= s3_rd_q;
    end
    if (rdy[4]) begin
      for (int i = 0; i < NUM_VOLUMES; i++) begin
        s5_mask_q[i] <= s4_lo_q[i] < s4_hi_q[i];
        s5_len_q[i]  <= len_d[i][cvsm_pkg::SectorW-1:0];
        s5_off_q[i]  <= off_d[i][cvsm_pkg::SectorW-1:0];
      end
      s5_pe_q <= s4_pe_q;
      s5_rd_q <= s4_rd_q;
    end
  end

  assign seg_valid_o        = v_q[NumStages-1];
  assign seg_ctl_o.rd       = s5_rd_q;
  assign seg_ctl_o.past_end = s5_pe_q;
  assign seg_mask_o         = s5_mask_q;
  assign seg_off_o          = s5_off_q;
  assign seg_len_o          = s5_len_q;

endmodule

`default_nettype wire

@@ src/cvsm_emit.sv @@
// Segment emitter: holds one request's segment list, sends one segment per cycle unless stalled.
// Depends on cvsm_pkg; fed by cvsm_split, bases from cvsm_regs.
`default_nettype none

module cvsm_emit #(
  parameter int NUM_VOLUMES = cvsm_pkg::DefNumVolumes
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         seg_valid_i,
  output logic                              seg_ready_o,
  input  wire cvsm_pkg::ctl_t               seg_ctl_i,
  input  wire logic [NUM_VOLUMES-1:0]       seg_mask_i,
  input  wire logic [cvsm_pkg::SectorW-1:0] seg_off_i [NUM_VOLUMES],
  input  wire logic [cvsm_pkg::SectorW-1:0] seg_len_i [NUM_VOLUMES],
  input  wire logic [cvsm_pkg::SectorW-1:0] vol_base_i [NUM_VOLUMES],
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [cvsm_pkg::VolIdxW-1:0] volume_index_o,
  output logic      [cvsm_pkg::PhysW-1:0]   phys_sector_o,
  output logic      [cvsm_pkg::SectorW-1:0] seg_length_o,
  output logic                              access_read_o,
  output logic                              last_segment_o,
  output logic                              past_end_o
);

  logic                         em_valid_q;
  logic [NUM_VOLUMES-1:0]       em_mask_q;
  logic [cvsm_pkg::PhysW-1:0]   em_phys_q [NUM_VOLUMES];
  logic [cvsm_pkg::SectorW-1:0] em_len_q [NUM_VOLUMES];
  cvsm_pkg::ctl_t               em_ctl_q;

  logic [NUM_VOLUMES-1:0]       sel;
  logic                         found;
  logic                         is_last;
  logic                         out_acc;
  logic                         load;

  // lowest pending volume goes first
  always_comb begin
    sel            = '0;
    found          = 1'b0;
    volume_index_o = '0;
    phys_sector_o  = '0;
    seg_length_o   = '0;
    for (int i = 0; i < NUM_VOLUMES; i++) begin
      if (em_mask_q[i] && !found) begin
        found          = 1'b1;
        sel[i]         = 1'b1;
        volume_index_o = cvsm_pkg::VolIdxW'(i);
        phys_sector_o  = em_phys_q[i];
        seg_length_o   = em_len_q[i];
      end
    end
  end

  // an empty mask is the single empty result
  assign is_last     = (em_mask_q & ~sel) == '0;
  assign out_acc     = em_valid_q && !out_stall_i;
  assign load        = !em_valid_q || (out_acc && is_last);
  assign seg_ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
    end else if (load) begin
      em_valid_q <= seg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      em_mask_q <= seg_mask_i;
      em_ctl_q  <= seg_ctl_i;
      for (int i = 0; i < NUM_VOLUMES; i++) begin
        em_phys_q[i] <= cvsm_pkg::PhysW'(vol_base_i[i]) + cvsm_pkg::PhysW'(seg_off_i[i]);
        em_len_q[i]  <= seg_len_i[i];
      end
    end else if (out_acc) begin
      em_mask_q <= em_mask_q & ~sel;
    end
  end

  assign out_valid_o    = em_valid_q;
  assign access_read_o  = em_ctl_q.rd;
  assign last_segment_o = is_last;
  assign past_end_o     = is_last && (em_ctl_q.past_end || !found);

endmodule

`default_nettype wire

@@ src/concat_volume_segment_mapper.sv @@
// Top level of the concatenated volume segment mapper.
// Depends on cvsm_pkg, cvsm_regs, cvsm_split and cvsm_emit.
//
//   channel   direction  handshake              payload
//   request   in         in_valid_i/in_stall_o  start_sector_i, sector_count_i, is_read_i
//   segment   out        out_valid_o/out_stall_i volume_index_o .. past_end_o
//   config    in         APB psel/penable        paddr, pwdata, prdata (8 x 48-bit regs)
//
// Five-stage split pipeline, then an emitter register that the first segment leaves
// from. Each request then occupies the single output port for one segment per touched
// volume (at least one), which sets the sustained rate.
// Reset clears the pipeline valid bits and all volume size/base registers.
// Output stall backs up through the pipeline; requests are taken while stages are free.
`default_nettype none

module concat_volume_segment_mapper #(
  parameter int NUM_VOLUMES = cvsm_pkg::DefNumVolumes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cvsm_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [cvsm_pkg::CfgDataW-1:0] pwdata,
  output logic      [cvsm_pkg::CfgDataW-1:0] prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [cvsm_pkg::SectorW-1:0]  start_sector_i,
  input  wire logic [cvsm_pkg::SectorW-1:0]  sector_count_i,
  input  wire logic                          is_read_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [cvsm_pkg::VolIdxW-1:0]  volume_index_o,
  output logic      [cvsm_pkg::PhysW-1:0]    phys_sector_o,
  output logic      [cvsm_pkg::SectorW-1:0]  seg_length_o,
  output logic                               access_read_o,
  output logic                               last_segment_o,
  output logic                               past_end_o
);

  logic [cvsm_pkg::SectorW-1:0] vol_size [NUM_VOLUMES];
  logic [cvsm_pkg::SectorW-1:0] vol_base [NUM_VOLUMES];
  logic                         seg_valid;
  logic                         seg_ready;
  cvsm_pkg::ctl_t               seg_ctl;
  logic [NUM_VOLUMES-1:0]       seg_mask;
  logic [cvsm_pkg::SectorW-1:0] seg_off [NUM_VOLUMES];
  logic [cvsm_pkg::SectorW-1:0] seg_len [NUM_VOLUMES];

  assign pready = 1'b1;

  cvsm_regs #(
    .NUM_VOLUMES (NUM_VOLUMES)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .vol_size_o (vol_size),
    .vol_base_o (vol_base)
  );

  cvsm_split #(
    .NUM_VOLUMES (NUM_VOLUMES)
  ) u_split (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_sector_i (start_sector_i),
    .sector_count_i (sector_count_i),
    .is_read_i      (is_read_i),
    .vol_size_i     (vol_size),
    .seg_valid_o    (seg_valid),
    .seg_ready_i    (seg_ready),
    .seg_ctl_o      (seg_ctl),
    .seg_mask_o     (seg_mask),
    .seg_off_o      (seg_off),
    .seg_len_o      (seg_len)
  );

  cvsm_emit #(
    .NUM_VOLUMES (NUM_VOLUMES)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seg_valid_i    (seg_valid),
    .seg_ready_o    (seg_ready),
    .seg_ctl_i      (seg_ctl),
    .seg_mask_i     (seg_mask),
    .seg_off_i      (seg_off),
    .seg_len_i      (seg_len),
    .vol_base_i     (vol_base),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .volume_index_o (volume_index_o),
    .phys_sector_o  (phys_sector_o),
    .seg_length_o   (seg_length_o),
    .access_read_o  (access_read_o),
    .last_segment_o (last_segment_o),
    .past_end_o     (past_end_o)
  );

endmodule

`default_nettype wire
